// ===== rtl/http_header_framer_unit_macros.svh =====
// Assertion macros shared by the framer RTL.
`ifndef HTTP_HEADER_FRAMER_UNIT_MACROS_SVH
`define HTTP_HEADER_FRAMER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define HHF_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define HHF_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/hhf_pkg.sv =====
// Shared types, character codes and helper functions of the HTTP header framer.
package hhf_pkg;

    localparam int COUNT_BITS_DEFAULT = 32;

    localparam logic [3:0] NAME_LAST = 4'd13;

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    localparam logic [23:0] TAIL_CR_LF_CR = 24'h0D0A0D;

    localparam logic [63:0] MAG_LIMIT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MAG_LIMIT_NEG = 64'h8000_0000_0000_0000;

    typedef enum logic [5:0] {
        LP_LEAD  = 6'b000001,
        LP_NAME  = 6'b000010,
        LP_BLANK = 6'b000100,
        LP_SKIP  = 6'b001000,
        LP_VALUE = 6'b010000,
        LP_DONE  = 6'b100000
    } line_phase_t;

    typedef enum logic [7:0] {
        VP_EMPTY   = 8'b00000001,
        VP_WS      = 8'b00000010,
        VP_SIGN    = 8'b00000100,
        VP_DIGITS  = 8'b00001000,
        VP_BAD     = 8'b00010000,
        VP_OK      = 8'b00100000,
        VP_INVALID = 8'b01000000,
        VP_RANGE   = 8'b10000000
    } value_phase_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_FIELD = 2'd1,
        STATUS_INVALID  = 2'd2,
        STATUS_RANGE    = 2'd3
    } length_status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_message;
    } beat_t;

    typedef struct packed {
        logic [31:0]        header_length;
        logic signed [63:0] body_length;
        logic [1:0]         length_status;
    } result_t;

    function automatic logic [7:0] lower_ascii(input logic [7:0] b);
        if (b >= 8'h41 && b <= 8'h5A)
        begin
            return b + 8'h20;
        end
        return b;
    endfunction

    // Lower-case spelling of the Content-Length field name.
    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h63; // c
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h6C; // l
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/hhf_in_reg.sv =====
// Input register of the framer: holds one accepted beat until the parser takes it.
module hhf_in_reg
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  hhf_pkg::beat_t beat_in,
    input  logic           advance,
    output logic           beat_valid,
    output hhf_pkg::beat_t beat_out
);

    logic           valid_reg;
    logic           valid_next;
    hhf_pkg::beat_t beat_reg;

    // A new beat may enter when the slot is empty or is being drained this cycle.
    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            beat_reg <= beat_in;
        end
    end

    assign beat_valid = valid_reg;
    assign beat_out   = beat_reg;

endmodule

// ===== rtl/hhf_parser.sv =====
// Per-byte header parser: line and value state, byte count and result formation.
module hhf_parser
#(
    parameter int COUNT_BITS = hhf_pkg::COUNT_BITS_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  hhf_pkg::beat_t   beat,
    input  logic             advance,
    output logic             result_hit,
    output hhf_pkg::result_t result
);

    logic [COUNT_BITS-1:0]  byte_count_reg, byte_count_next, cur_count;
    logic [23:0]            recent_reg, recent_next, cur_recent;
    hhf_pkg::line_phase_t   line_phase_reg, line_phase_next, cur_lp, work_lp;
    logic [3:0]             name_index_reg, name_index_next, cur_ni, work_ni;
    logic                   found_reg, found_next, cur_found;
    hhf_pkg::value_phase_t  value_phase_reg, value_phase_next, cur_vp, pre_vp;
    logic                   negative_reg, negative_next, cur_neg;
    logic [63:0]            magnitude_reg, magnitude_next, cur_mag;
    logic                   range_reg, range_next, cur_range;
    logic                   done_reg, done_next, cur_done;

    logic [7:0]  b;
    logic        is_blank, is_ws, is_digit, is_sign, prev_cr, line_end, lead_skip;
    logic [67:0] mag_wide, mag_limit;
    logic        digit_over;
    logic        header_end;
    logic [63:0] count_ext;

    assign b = beat.data_byte;

    // A start flag clears all parse state before this byte is looked at.
    always_comb
    begin
        if (beat.start_message)
        begin
            cur_count = '0;
            cur_recent = '0;
            cur_lp = hhf_pkg::LP_LEAD;
            cur_ni = '0;
            cur_found = 1'b0;
            cur_vp = hhf_pkg::VP_EMPTY;
            cur_neg = 1'b0;
            cur_mag = '0;
            cur_range = 1'b0;
            cur_done = 1'b0;
        end
        else
        begin
            cur_count = byte_count_reg;
            cur_recent = recent_reg;
            cur_lp = line_phase_reg;
            cur_ni = name_index_reg;
            cur_found = found_reg;
            cur_vp = value_phase_reg;
            cur_neg = negative_reg;
            cur_mag = magnitude_reg;
            cur_range = range_reg;
            cur_done = done_reg;
        end
    end

    assign is_blank = (b == hhf_pkg::CHAR_SPACE) || (b == hhf_pkg::CHAR_TAB);
    assign is_ws    = is_blank || (b == hhf_pkg::CHAR_LF) || (b == hhf_pkg::CHAR_VT)
                      || (b == hhf_pkg::CHAR_FF) || (b == hhf_pkg::CHAR_CR);
    assign is_digit = (b >= hhf_pkg::CHAR_ZERO) && (b <= hhf_pkg::CHAR_NINE);
    assign is_sign  = (b == hhf_pkg::CHAR_PLUS) || (b == hhf_pkg::CHAR_MINUS);
    assign prev_cr  = (cur_recent[7:0] == hhf_pkg::CHAR_CR);
    assign line_end = prev_cr && (b == hhf_pkg::CHAR_LF);

    // Leading blanks are dropped only on the first line of the message.
    assign lead_skip = (cur_lp == hhf_pkg::LP_LEAD) && is_blank;
    assign work_lp   = (cur_lp == hhf_pkg::LP_LEAD) ? hhf_pkg::LP_NAME : cur_lp;
    assign work_ni   = (cur_lp == hhf_pkg::LP_LEAD) ? 4'd0 : cur_ni;

    // Digit accumulate: 10*m + d is checked against the signed limit, which is
    // the same test as m > (limit - d) / 10.
    assign mag_wide   = ({4'b0, cur_mag} << 3) + ({4'b0, cur_mag} << 1) + {64'b0, b[3:0]};
    assign mag_limit  = {4'b0, (cur_neg ? hhf_pkg::MAG_LIMIT_NEG : hhf_pkg::MAG_LIMIT_POS)};
    assign digit_over = mag_wide > mag_limit;

    // A lone CR after a sign or digits spoils the value.
    assign pre_vp = (prev_cr && ((cur_vp == hhf_pkg::VP_SIGN) || (cur_vp == hhf_pkg::VP_DIGITS)))
                    ? hhf_pkg::VP_BAD : cur_vp;

    always_comb
    begin
        line_phase_next = cur_lp;
        name_index_next = cur_ni;
        found_next = cur_found;
        value_phase_next = cur_vp;
        negative_next = cur_neg;
        magnitude_next = cur_mag;
        range_next = cur_range;
        if (!lead_skip)
        begin
            line_phase_next = work_lp;
            name_index_next = work_ni;
            unique case (work_lp)
                hhf_pkg::LP_NAME:
                begin
                    if (hhf_pkg::lower_ascii(b) == hhf_pkg::name_char(work_ni))
                    begin
                        name_index_next = work_ni + 4'd1;
                        if (work_ni == hhf_pkg::NAME_LAST)
                        begin
                            line_phase_next = hhf_pkg::LP_BLANK;
                        end
                    end
                    else
                    begin
                        line_phase_next = hhf_pkg::LP_SKIP;
                    end
                end
                hhf_pkg::LP_BLANK:
                begin
                    if (b == hhf_pkg::CHAR_COLON)
                    begin
                        found_next = 1'b1;
                        line_phase_next = hhf_pkg::LP_VALUE;
                        value_phase_next = hhf_pkg::VP_WS;
                    end
                    else if (!is_blank)
                    begin
                        line_phase_next = hhf_pkg::LP_SKIP;
                    end
                end
                hhf_pkg::LP_SKIP:
                begin
                    if (line_end)
                    begin
                        line_phase_next = hhf_pkg::LP_NAME;
                        name_index_next = 4'd0;
                    end
                end
                hhf_pkg::LP_VALUE:
                begin
                    if (line_end)
                    begin
                        line_phase_next = hhf_pkg::LP_DONE;
                        if (cur_vp == hhf_pkg::VP_DIGITS)
                        begin
                            value_phase_next = cur_range ? hhf_pkg::VP_RANGE : hhf_pkg::VP_OK;
                        end
                        else if (cur_vp == hhf_pkg::VP_BAD)
                        begin
                            value_phase_next = cur_range ? hhf_pkg::VP_RANGE
                                                         : hhf_pkg::VP_INVALID;
                        end
                        else
                        begin
                            value_phase_next = hhf_pkg::VP_INVALID;
                        end
                    end
                    else
                    begin
                        value_phase_next = pre_vp;
                        if (pre_vp == hhf_pkg::VP_WS)
                        begin
                            if (is_ws)
                            begin
                                value_phase_next = hhf_pkg::VP_WS;
                            end
                            else if (is_sign)
                            begin
                                negative_next = (b == hhf_pkg::CHAR_MINUS);
                                value_phase_next = hhf_pkg::VP_SIGN;
                            end
                            else if (is_digit)
                            begin
                                value_phase_next = hhf_pkg::VP_DIGITS;
                            end
                            else
                            begin
                                value_phase_next = hhf_pkg::VP_BAD;
                            end
                        end
                        else if ((pre_vp == hhf_pkg::VP_SIGN) || (pre_vp == hhf_pkg::VP_DIGITS))
                        begin
                            if (is_digit)
                            begin
                                value_phase_next = hhf_pkg::VP_DIGITS;
                            end
                            else if (b != hhf_pkg::CHAR_CR)
                            begin
                                value_phase_next = hhf_pkg::VP_BAD;
                            end
                        end
                        if (is_digit && !cur_range
                            && ((pre_vp == hhf_pkg::VP_WS) || (pre_vp == hhf_pkg::VP_SIGN)
                                || (pre_vp == hhf_pkg::VP_DIGITS)))
                        begin
                            if (digit_over)
                            begin
                                range_next = 1'b1;
                            end
                            else
                            begin
                                magnitude_next = mag_wide[63:0];
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign byte_count_next = (cur_count == '1) ? cur_count : cur_count + COUNT_BITS'(1);
    assign recent_next     = {cur_recent[15:0], b};
    assign header_end      = (cur_recent == hhf_pkg::TAIL_CR_LF_CR) && (b == hhf_pkg::CHAR_LF);
    assign done_next       = header_end;
    assign result_hit      = !cur_done && header_end;

    assign count_ext = 64'(byte_count_next);

    always_comb
    begin
        result.header_length = (count_ext > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF
                                                                     : count_ext[31:0];
        result.body_length = '0;
        if (!found_next)
        begin
            result.length_status = hhf_pkg::STATUS_NO_FIELD;
        end
        else if (value_phase_next == hhf_pkg::VP_OK)
        begin
            result.length_status = hhf_pkg::STATUS_OK;
            result.body_length = negative_next ? $signed(64'd0 - magnitude_next)
                                               : $signed(magnitude_next);
        end
        else if (value_phase_next == hhf_pkg::VP_RANGE)
        begin
            result.length_status = hhf_pkg::STATUS_RANGE;
        end
        else
        begin
            result.length_status = hhf_pkg::STATUS_INVALID;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            recent_reg <= '0;
            line_phase_reg <= hhf_pkg::LP_LEAD;
            name_index_reg <= '0;
            found_reg <= 1'b0;
            value_phase_reg <= hhf_pkg::VP_EMPTY;
            negative_reg <= 1'b0;
            magnitude_reg <= '0;
            range_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (cur_done)
            begin
                // Bytes after the header end leave the state alone.
                byte_count_reg <= cur_count;
                recent_reg <= cur_recent;
                line_phase_reg <= cur_lp;
                name_index_reg <= cur_ni;
                found_reg <= cur_found;
                value_phase_reg <= cur_vp;
                negative_reg <= cur_neg;
                magnitude_reg <= cur_mag;
                range_reg <= cur_range;
                done_reg <= cur_done;
            end
            else
            begin
                byte_count_reg <= byte_count_next;
                recent_reg <= recent_next;
                line_phase_reg <= line_phase_next;
                name_index_reg <= name_index_next;
                found_reg <= found_next;
                value_phase_reg <= value_phase_next;
                negative_reg <= negative_next;
                magnitude_reg <= magnitude_next;
                range_reg <= range_next;
                done_reg <= done_next;
            end
        end
    end

endmodule

// ===== rtl/http_header_framer_unit.sv =====
// Top level of the HTTP header framer: input register, parser and result register.
//
//  Channel   Dir  tdata                                    tuser
//  s_axis    in   data_byte[7:0]                           start_message
//  m_axis    out  header_length[31:0], body_length[95:32]  length_status[1:0]
//
// One byte is parsed per cycle while no header end waits; the byte count, the
// 10*m+d accumulate and limit compare sit between input and result registers.
// A beat is held in the input register before it reaches the result register.
// rst_n clears the parse state, the way a start_message beat does.
// A beat that ends the header waits in the input register while a result is
// still held; other beats flow on regardless of the output side.
module http_header_framer_unit
#(
    parameter int COUNT_BITS = hhf_pkg::COUNT_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tuser,   // start_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // header_length[31:0], body_length[95:32]
    output logic [1:0]  m_tuser    // length_status[1:0]
);

    `include "http_header_framer_unit_macros.svh"

    hhf_pkg::beat_t   beat_in;
    hhf_pkg::beat_t   beat_held;
    logic             beat_valid;
    logic             advance;
    logic             result_hit;
    logic             out_free;
    hhf_pkg::result_t result;
    hhf_pkg::result_t result_reg;
    logic             out_valid_reg;
    logic             out_valid_next;

    assign beat_in.data_byte     = s_tdata;
    assign beat_in.start_message = s_tuser;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = beat_valid && (!result_hit || out_free);

    hhf_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .beat_in    (beat_in),
        .advance    (advance),
        .beat_valid (beat_valid),
        .beat_out   (beat_held)
    );

    hhf_parser #(
        .COUNT_BITS (COUNT_BITS)
    ) u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat       (beat_held),
        .advance    (advance),
        .result_hit (result_hit),
        .result     (result)
    );

    always_comb
    begin
        if (advance && result_hit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && result_hit)
        begin
            result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {result_reg.body_length, result_reg.header_length};
    assign m_tuser  = result_reg.length_status;

    `HHF_ASSERT_NEXT(a_result_loaded, advance && result_hit, m_tvalid,
        "result beat not presented")
    `HHF_ASSERT_NOW(a_bad_len_zero, m_tvalid && (m_tuser != hhf_pkg::STATUS_OK),
        m_tdata[95:32] == 64'd0, "nonzero body length with error status")
    `HHF_ASSERT_NOW(a_min_header, m_tvalid, m_tdata[31:0] >= 32'd4,
        "header shorter than the blank line")
    `HHF_ASSERT_NOW(a_no_overwrite, result_hit && out_valid_reg && !m_tready, !advance,
        "held result would be overwritten")

endmodule

// ===== tb/http_header_framer_checker.sv =====
// Checker that predicts and compares the header results of the HTTP header framer.
`timescale 1ns / 1ps

module http_header_framer_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [95:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          mismatches,
    output int          headers_waiting,
    output int          bytes_seen,
    output int          headers_checked
);
    import hhf_pkg::*;

    localparam logic [111:0] CL_SPELLING = "content-length";

    typedef struct {
        logic [31:0]    hlen;
        logic [63:0]    blen;
        length_status_t status;
    } framing_t;

    // Parse state of the message that is currently arriving.
    logic [31:0]  hdr_bytes;
    logic [23:0]  last3;
    line_phase_t  line_st;
    logic [3:0]   name_pos;
    bit           cl_seen;
    value_phase_t val_st;
    bit           val_neg;
    logic [63:0]  val_mag;
    bit           val_ovf;
    bit           hdr_closed;

    framing_t framings_due[$];
    framing_t want;
    int       errs;
    int       nbytes;
    int       nchecked;

    task automatic clear_parse();
        hdr_bytes  = '0;
        last3      = '0;
        line_st    = LP_LEAD;
        name_pos   = '0;
        cl_seen    = 1'b0;
        val_st     = VP_EMPTY;
        val_neg    = 1'b0;
        val_mag    = '0;
        val_ovf    = 1'b0;
        hdr_closed = 1'b0;
    endtask

    task automatic take_digit(input logic [7:0] b);
        logic [63:0] d;
        logic [63:0] lim;
        d   = {56'd0, b - CHAR_ZERO};
        lim = val_neg ? MAG_LIMIT_NEG : MAG_LIMIT_POS;
        if (!val_ovf)
        begin
            if (val_mag > (lim - d) / 64'd10)
                val_ovf = 1'b1;
            else
                val_mag = val_mag * 64'd10 + d;
        end
    endtask

    task automatic step_value(input logic [7:0] b, input bit prev_cr);
        bit digit;
        bit blank;
        digit = b >= CHAR_ZERO && b <= CHAR_NINE;
        blank = b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_LF || b == CHAR_VT ||
                b == CHAR_FF || b == CHAR_CR;
        if (b == CHAR_LF && prev_cr)
        begin
            // The line end settles the value for good.
            if ((val_st == VP_DIGITS || val_st == VP_BAD) && val_ovf)
                val_st = VP_RANGE;
            else if (val_st == VP_DIGITS)
                val_st = VP_OK;
            else
                val_st = VP_INVALID;
            line_st = LP_DONE;
        end
        else
        begin
            // A CR that was not followed by LF breaks a number already begun.
            if (prev_cr && (val_st == VP_SIGN || val_st == VP_DIGITS))
                val_st = VP_BAD;
            case (val_st)
                VP_WS:
                begin
                    if (!blank)
                    begin
                        if (b == CHAR_PLUS || b == CHAR_MINUS)
                        begin
                            val_neg = b == CHAR_MINUS;
                            val_st  = VP_SIGN;
                        end
                        else if (digit)
                        begin
                            take_digit(b);
                            val_st = VP_DIGITS;
                        end
                        else
                        begin
                            val_st = VP_BAD;
                        end
                    end
                end
                VP_SIGN, VP_DIGITS:
                begin
                    if (digit)
                    begin
                        take_digit(b);
                        val_st = VP_DIGITS;
                    end
                    else if (b != CHAR_CR)
                    begin
                        val_st = VP_BAD;
                    end
                end
                default:
                begin
                end
            endcase
        end
    endtask

    task automatic step_line(input logic [7:0] b, input bit prev_cr);
        logic [7:0] lc;
        lc = (b >= "A" && b <= "Z") ? b + 8'h20 : b;
        if (line_st == LP_LEAD && b != CHAR_SPACE && b != CHAR_TAB)
        begin
            line_st  = LP_NAME;
            name_pos = '0;
        end
        case (line_st)
            LP_NAME:
            begin
                if (name_pos <= NAME_LAST &&
                    lc == CL_SPELLING[8 * (int'(NAME_LAST) - int'(name_pos)) +: 8])
                begin
                    name_pos = name_pos + 4'd1;
                    if (name_pos > NAME_LAST)
                        line_st = LP_BLANK;
                end
                else
                begin
                    line_st = LP_SKIP;
                end
            end
            LP_BLANK:
            begin
                if (b == CHAR_COLON)
                begin
                    cl_seen = 1'b1;
                    line_st = LP_VALUE;
                    val_st  = VP_WS;
                end
                else if (b != CHAR_SPACE && b != CHAR_TAB)
                begin
                    line_st = LP_SKIP;
                end
            end
            LP_SKIP:
            begin
                if (b == CHAR_LF && prev_cr)
                begin
                    line_st  = LP_NAME;
                    name_pos = '0;
                end
            end
            LP_VALUE:
                step_value(b, prev_cr);
            default:
            begin
            end
        endcase
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic st);
        bit       prev_cr;
        bit       closing;
        framing_t got;
        if (st)
            clear_parse();
        if (!hdr_closed)
        begin
            if (hdr_bytes != 32'hFFFF_FFFF)
                hdr_bytes = hdr_bytes + 32'd1;
            prev_cr = last3[7:0] == CHAR_CR;
            step_line(b, prev_cr);
            closing = last3 == TAIL_CR_LF_CR && b == CHAR_LF;
            last3   = {last3[15:0], b};
            if (closing)
            begin
                hdr_closed = 1'b1;
                got.hlen   = hdr_bytes;
                got.blen   = '0;
                if (!cl_seen)
                    got.status = STATUS_NO_FIELD;
                else if (val_st == VP_OK)
                begin
                    got.status = STATUS_OK;
                    got.blen   = val_neg ? -val_mag : val_mag;
                end
                else if (val_st == VP_RANGE)
                    got.status = STATUS_RANGE;
                else
                    got.status = STATUS_INVALID;
                framings_due.push_back(got);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parse();
            framings_due.delete();
            errs     = 0;
            nbytes   = 0;
            nchecked = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                absorb_byte(s_tdata, s_tuser);
                nbytes++;
            end
            if (m_tvalid && m_tready)
            begin
                if (framings_due.size() == 0)
                begin
                    errs++;
                    $display("%0t: result with nothing expected, actual hlen %0d body %0d st %0d",
                             $time, m_tdata[31:0], $signed(m_tdata[95:32]), m_tuser);
                end
                else
                begin
                    want = framings_due.pop_front();
                    nchecked++;
                    if (m_tdata[31:0] !== want.hlen)
                    begin
                        errs++;
                        $display("%0t: header_length expected %0d actual %0d",
                                 $time, want.hlen, m_tdata[31:0]);
                    end
                    if (m_tdata[95:32] !== want.blen)
                    begin
                        errs++;
                        $display("%0t: body_length expected %0d actual %0d",
                                 $time, $signed(want.blen), $signed(m_tdata[95:32]));
                    end
                    if (m_tuser !== want.status)
                    begin
                        errs++;
                        $display("%0t: length_status expected %0d actual %0d",
                                 $time, want.status, m_tuser);
                    end
                end
            end
        end
        mismatches      <= errs;
        headers_waiting <= framings_due.size();
        bytes_seen      <= nbytes;
        headers_checked <= nchecked;
    end

endmodule

// ===== tb/tb_http_header_framer_unit.sv =====
// Testbench top of the HTTP header framer: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_http_header_framer_unit;
    import hhf_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 20;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic [1:0]  m_tuser;

    int mismatches;
    int headers_waiting;
    int bytes_seen;
    int headers_checked;

    int idle_pct   = 0;
    int stall_pct  = 0;
    bit hold_token = 1'b0;
    bit hold_seen  = 1'b0;
    int hold_left  = 0;
    int cycles     = 0;

    logic [7:0] frame_q[$];

    http_header_framer_unit u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    http_header_framer_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .mismatches      (mismatches),
        .headers_waiting (headers_waiting),
        .bytes_seen      (bytes_seen),
        .headers_checked (headers_checked)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Receiver: a toggle of hold_token starts a long hold-off, otherwise random stalls.
    always @(posedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen <= hold_token;
            hold_left <= LONG_HOLD;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= $urandom_range(99) >= stall_pct;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic add_byte(input logic [7:0] b);
        frame_q.push_back(b);
    endtask

    task automatic add_text(input string t);
        for (int i = 0; i < t.len(); i++)
            frame_q.push_back(t[i]);
    endtask

    task automatic add_crlf();
        frame_q.push_back(CHAR_CR);
        frame_q.push_back(CHAR_LF);
    endtask

    task automatic add_line(input string t);
        add_text(t);
        add_crlf();
    endtask

    task automatic add_junk(input int n, input int lo, input int hi);
        repeat (n)
            frame_q.push_back(8'($urandom_range(hi, lo)));
    endtask

    task automatic add_blanks(input int n);
        repeat (n)
            frame_q.push_back($urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
    endtask

    task automatic send_beat(input logic [7:0] b, input logic st);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= st;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Sends the queued bytes; stray starts restart the parse in mid-message.
    task automatic send_frame(input bit first_start, input bit stray_starts);
        for (int i = 0; i < frame_q.size(); i++)
            send_beat(frame_q[i], (i == 0) ? first_start :
                      (stray_starts && $urandom_range(19) == 0));
        frame_q.delete();
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (headers_waiting == 0);
        @(posedge clk);
    endtask

    task automatic add_cl_line(input bit first_line);
        string       nm;
        logic [7:0]  c;
        logic [63:0] r;
        nm = "content-length";
        if (first_line)
            add_blanks($urandom_range(2));
        else if ($urandom_range(9) == 0)
            add_blanks(1);
        for (int i = 0; i < nm.len(); i++)
        begin
            c = nm[i];
            if (c >= "a" && c <= "z" && $urandom_range(1))
                c = c - 8'h20;
            add_byte(c);
        end
        case ($urandom_range(19))
            0:       void'(frame_q.pop_back());
            1:       add_byte("s");
            default: ;
        endcase
        add_blanks($urandom_range(2));
        add_byte(CHAR_COLON);
        repeat ($urandom_range(2))
        begin
            case ($urandom_range(4))
                0:       add_byte(CHAR_SPACE);
                1:       add_byte(CHAR_TAB);
                2:       add_byte(CHAR_VT);
                3:       add_byte(CHAR_FF);
                default: add_byte(CHAR_LF);
            endcase
        end
        case ($urandom_range(9))
            0, 1, 2, 3:
            begin
                case ($urandom_range(2))
                    1:       add_byte(CHAR_PLUS);
                    2:       add_byte(CHAR_MINUS);
                    default: ;
                endcase
                add_text($sformatf("%0d", $urandom_range(99999)));
            end
            4:
            begin
                r = {$urandom, $urandom};
                add_text($sformatf("%0d", $signed(r)));
            end
            5:
            begin
                case ($urandom_range(3))
                    0:       add_text("9223372036854775807");
                    1:       add_text("-9223372036854775808");
                    2:       add_text("9223372036854775808");
                    default: add_text("-9223372036854775809");
                endcase
            end
            6:
            begin
                if ($urandom_range(1))
                    add_byte(CHAR_MINUS);
                repeat ($urandom_range(24, 19))
                    add_byte(CHAR_ZERO + 8'($urandom_range(9)));
            end
            7:
            begin
                if ($urandom_range(1))
                    add_byte($urandom_range(1) ? CHAR_PLUS : CHAR_MINUS);
            end
            8:
            begin
                add_text($sformatf("%0d", $urandom_range(999)));
                case ($urandom_range(2))
                    0:       add_byte(CHAR_SPACE);
                    1:       add_byte("x");
                    default:
                    begin
                        add_byte(CHAR_CR);
                        add_byte(CHAR_ZERO + 8'($urandom_range(9)));
                    end
                endcase
            end
            default:
                add_junk($urandom_range(5, 1), 0, 255);
        endcase
        add_crlf();
    endtask

    task automatic random_message();
        int lines;
        int cl_pos;
        bit with_cl;
        lines   = $urandom_range(3);
        cl_pos  = $urandom_range(lines);
        with_cl = $urandom_range(6) != 0;
        if ($urandom_range(3) == 0)
        begin
            // Noise: arbitrary bytes with scattered line ends, maybe a header end.
            repeat ($urandom_range(24, 1))
            begin
                if ($urandom_range(4) == 0)
                    add_crlf();
                else
                    add_byte(8'($urandom_range(255)));
            end
            if ($urandom_range(1))
            begin
                add_crlf();
                add_crlf();
            end
            send_frame($urandom_range(1), 1'b1);
        end
        else
        begin
            for (int k = 0; k <= lines; k++)
            begin
                if (with_cl && k == cl_pos)
                    add_cl_line(k == 0);
                else
                begin
                    add_junk($urandom_range(8, 1), 8'h21, 8'h7E);
                    add_byte(CHAR_COLON);
                    add_junk($urandom_range(6), 8'h20, 8'h7E);
                    add_crlf();
                end
            end
            add_crlf();
            if ($urandom_range(3) == 0)
                add_junk($urandom_range(8, 1), 0, 255);
            send_frame(1'b1, 1'b0);
        end
    endtask

    initial
    begin
        int idle_mix[4];
        int stall_mix[4];
        int goal;
        int byte_mark;
        idle_mix  = '{0, 86, 0, 15};
        stall_mix = '{0, 0, 86, 15};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_line("  content-LENGTH \t: \t 123");
        add_crlf();
        send_frame(1'b1, 1'b0);
        add_line("GET / HTTP/1.1");
        add_line("Content-Length: -9223372036854775808");
        add_crlf();
        send_frame(1'b1, 1'b0);
        add_line("Content-Length:9223372036854775807");
        add_crlf();
        send_frame(1'b1, 1'b0);
        // Overflow is reported even when junk follows the digits.
        add_line("Content-Length: -92233720368547758090x");
        add_crlf();
        send_frame(1'b1, 1'b0);
        add_line("Content-Length: ");
        add_crlf();
        send_frame(1'b1, 1'b0);
        add_line("Content-Length: -");
        add_crlf();
        send_frame(1'b1, 1'b0);
        add_line("Content-Length: 12 ");
        add_crlf();
        send_frame(1'b1, 1'b0);
        add_text("Content-Length:");
        add_byte(CHAR_CR);
        add_line(" 7");
        add_crlf();
        send_frame(1'b1, 1'b0);
        add_text("Content-Length: 7");
        add_byte(CHAR_CR);
        add_line("8");
        add_crlf();
        send_frame(1'b1, 1'b0);
        add_text("Content-Length:");
        add_byte(CHAR_TAB);
        add_byte(CHAR_VT);
        add_byte(CHAR_FF);
        add_byte(CHAR_LF);
        add_line(" +0");
        add_crlf();
        send_frame(1'b1, 1'b0);
        add_line("Host: a");
        add_crlf();
        add_line("Content-Length: 3");
        send_frame(1'b1, 1'b0);
        add_line("X");
        add_line(" Content-Length: 5");
        add_crlf();
        send_frame(1'b1, 1'b0);
        add_line("content-length: 1");
        add_line("Content-Length: 2");
        add_crlf();
        send_frame(1'b1, 1'b0);
        add_crlf();
        add_crlf();
        send_frame(1'b1, 1'b0);
        // Without a start beat the bytes after a finished header are ignored.
        add_line("Content-Length: 1");
        add_crlf();
        send_frame(1'b0, 1'b0);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_line(": x");
        add_crlf();
        send_frame(1'b1, 1'b0);
        add_line("Content-Length:: 4");
        add_crlf();
        send_frame(1'b1, 1'b0);
        drain();

        // Long receiver hold-off while short messages keep coming.
        hold_token <= ~hold_token;
        repeat (6)
        begin
            add_crlf();
            add_crlf();
            send_frame(1'b1, 1'b0);
        end
        drain();

        for (int p = 0; p < 4; p++)
        begin
            idle_pct  = idle_mix[p];
            stall_pct = stall_mix[p];
            goal      = headers_checked + headers_waiting + 1;
            byte_mark = bytes_seen + 20;
            while (headers_checked + headers_waiting < goal || bytes_seen < byte_mark)
                random_message();
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d bytes; %0d header results checked over directed cases,",
                 bytes_seen, headers_checked);
        $display("a long output hold-off and four sender/receiver idle mixes.");
        if (mismatches == 0 && headers_waiting == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
